// ----- rtl/hpdm_pkg.sv -----
// Shared types and constants for the heading-hold PI mixer.
// Used by the controller, the datapath and the top level; depends on nothing.
package hpdm_pkg;

    // Request codes carried by the request type field.
    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_LOCK_ON  = 2'd1,
        REQ_LOCK_OFF = 2'd2,
        REQ_ROTATE   = 2'd3
    } t_req;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_CORR_LIM_ROT   = 3'd2,
        REG_CORR_LIM_DRV   = 3'd3,
        REG_INTEG_LIM_ROT  = 3'd4,
        REG_INTEG_LIM_DRV  = 3'd5,
        REG_HALF_BASE      = 3'd6,
        REG_MAX_WHEEL      = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_DIV1, ST_DIV2, ST_DIV3, ST_PMUL, ST_IMUL,
        ST_SUM, ST_CORR, ST_OMEGA, ST_MIX1, ST_MIX2, ST_MIX3, ST_DONE
    } t_state;

    // Datapath operation for the current cycle.
    typedef enum logic [3:0] {
        OP_NONE, OP_ERR, OP_DIV1, OP_DIV2, OP_DIV3, OP_PMUL, OP_IMUL,
        OP_SUM, OP_CORR, OP_OMEGA, OP_MIX1, OP_MIX2, OP_MIX3
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic locked;
    } t_sts;

    // Deadband of 0.5 degree in Q16.16 radians.
    localparam logic signed [31:0] DEADBAND_Q = 32'sd572;
    // Half of the tick count per second, added before dividing by it.
    localparam logic [31:0] TICK_HALF = 32'd500;
    localparam logic signed [32:0] TICKS_PER_SEC = 33'sd1000;
    // floor(2^41 / 1000): reciprocal of the tick rate.
    localparam logic [31:0] TICK_RECIP = 32'd2199023255;
    localparam int RECIP_SHIFT = 41;
    localparam int QUOT_W = 64 - RECIP_SHIFT;

endpackage

// ----- rtl/hpdm_ctrl.sv -----
// Sequencer for the heading-hold PI mixer: steps the datapath through one request.
// Depends on hpdm_pkg for the state, operation and command types.
module hpdm_ctrl
    import hpdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   load_out;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_req'(i_req_type))
                        REQ_TICK:     n_state = i_sts.locked ? ST_ERR : ST_OMEGA;
                        REQ_LOCK_OFF: n_state = ST_DONE;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ERR:   n_state = ST_DIV1;
            ST_DIV1:  n_state = ST_DIV2;
            ST_DIV2:  n_state = ST_DIV3;
            ST_DIV3:  n_state = ST_PMUL;
            ST_PMUL:  n_state = ST_IMUL;
            ST_IMUL:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_CORR;
            ST_CORR:  n_state = ST_OMEGA;
            ST_OMEGA: n_state = ST_MIX1;
            ST_MIX1:  n_state = ST_MIX2;
            ST_MIX2:  n_state = ST_MIX3;
            ST_MIX3:  n_state = ST_DONE;
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.load_out = load_out;
        case (r_state)
            ST_ERR:   o_cmd.op = OP_ERR;
            ST_DIV1:  o_cmd.op = OP_DIV1;
            ST_DIV2:  o_cmd.op = OP_DIV2;
            ST_DIV3:  o_cmd.op = OP_DIV3;
            ST_PMUL:  o_cmd.op = OP_PMUL;
            ST_IMUL:  o_cmd.op = OP_IMUL;
            ST_SUM:   o_cmd.op = OP_SUM;
            ST_CORR:  o_cmd.op = OP_CORR;
            ST_OMEGA: o_cmd.op = OP_OMEGA;
            ST_MIX1:  o_cmd.op = OP_MIX1;
            ST_MIX2:  o_cmd.op = OP_MIX2;
            ST_MIX3:  o_cmd.op = OP_MIX3;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/hpdm_dp.sv -----
// Datapath of the heading-hold PI mixer: loop state, one shared multiplier,
// rounding, clamping and the output register. Depends on hpdm_pkg.
module hpdm_dp
    import hpdm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_gyro_angle,
    input  logic signed [31:0] i_planned_speed,
    input  logic signed [31:0] i_planned_turn_rate,
    input  logic               i_rotation_active,
    input  logic signed [31:0] i_profile_angle,
    input  logic [30:0]        i_prop_gain,
    input  logic [30:0]        i_integ_gain,
    input  logic [30:0]        i_corr_limit_rotating,
    input  logic [30:0]        i_corr_limit_driving,
    input  logic [30:0]        i_integ_limit_rotating,
    input  logic [30:0]        i_integ_limit_driving,
    input  logic [30:0]        i_half_wheel_base,
    input  logic [30:0]        i_max_wheel_speed,
    output logic signed [31:0] o_left_speed,
    output logic signed [31:0] o_right_speed,
    output logic signed [31:0] o_heading_correction,
    output logic               o_lock_active
);

    // Loop state.
    logic                      r_lock;
    logic signed [31:0]        r_target;
    logic signed [31:0]        r_integ;

    // Latched request.
    logic signed [31:0]        r_gyro, r_speed, r_turn, r_prof;
    logic                      r_rot;

    // Working registers.
    logic signed [31:0]        r_err;
    logic signed [31:0]        r_ibase;
    logic [31:0]               r_mag;
    logic                      r_neg;
    logic [QUOT_W-1:0]         r_quot;
    logic signed [63:0]        r_prod;
    logic signed [63:0]        r_acc;
    logic signed [31:0]        r_corr;
    logic signed [31:0]        r_omega;
    logic signed [47:0]        r_diff;
    logic signed [31:0]        r_left, r_right;

    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        mul_p;

    logic [30:0]               corr_lim, integ_lim;
    logic signed [31:0]        tgt;
    logic signed [32:0]        err_dif;
    logic signed [31:0]        err_sat;
    logic                      in_dead;
    logic signed [31:0]        err_z;
    logic signed [32:0]        err_abs;
    logic [QUOT_W-1:0]         quot0;
    logic [32:0]               rem;
    logic [QUOT_W-1:0]         quot;
    logic signed [QUOT_W:0]    quot_s;
    logic signed [33:0]        integ_sum;
    logic signed [33:0]        ilim_s;
    logic signed [31:0]        integ_clamped;
    logic signed [63:0]        acc_sum;
    logic signed [47:0]        acc_rnd;
    logic signed [47:0]        clim_s;
    logic signed [31:0]        corr_clamped;
    logic signed [32:0]        omega_sum;
    logic signed [31:0]        omega_sat;
    logic signed [47:0]        prod_rnd;
    logic signed [48:0]        vmax_s;
    logic signed [48:0]        left_raw, right_raw;
    logic signed [31:0]        left_sat, right_sat;

    // Drop 16 fraction bits, rounding to nearest with ties away from zero.
    function automatic logic signed [47:0] round_q16(input logic signed [63:0] x);
        logic signed [63:0] s;
        s = x + 64'sd32767 + $signed({63'd0, ~x[63]});
        return s[63:16];
    endfunction

    assign corr_lim  = r_rot ? i_corr_limit_rotating  : i_corr_limit_driving;
    assign integ_lim = r_rot ? i_integ_limit_rotating : i_integ_limit_driving;

    // Error with saturation and deadband.
    always_comb begin
        tgt     = r_rot ? r_prof : r_target;
        err_dif = {tgt[31], tgt} - {r_gyro[31], r_gyro};
        if (err_dif[32] != err_dif[31]) begin
            err_sat = err_dif[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            err_sat = err_dif[31:0];
        end
        in_dead = (err_sat > -DEADBAND_Q) && (err_sat < DEADBAND_Q);
        err_z   = in_dead ? 32'sd0 : err_sat;
        err_abs = err_z[31] ? -{err_z[31], err_z} : {err_z[31], err_z};
    end

    // Division of the error by the tick rate, finished from the reciprocal estimate, then the clamped integral update.
    always_comb begin
        quot0     = r_prod[63:RECIP_SHIFT];
        rem       = {1'b0, r_mag} - r_prod[32:0];
        quot      = (rem >= 33'(TICKS_PER_SEC)) ? r_quot + 1'b1 : r_quot;
        quot_s    = r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        integ_sum = 34'(r_ibase) + 34'(quot_s);
        ilim_s    = $signed({3'd0, integ_lim});
        if (integ_sum > ilim_s) begin
            integ_clamped = ilim_s[31:0];
        end else if (integ_sum < -ilim_s) begin
            integ_clamped = -ilim_s[31:0];
        end else begin
            integ_clamped = integ_sum[31:0];
        end
    end

    // PI sum, rounding and correction clamp.
    always_comb begin
        acc_sum = r_acc + r_prod;
        acc_rnd = round_q16(r_acc);
        clim_s  = $signed({17'd0, corr_lim});
        if (acc_rnd > clim_s) begin
            corr_clamped = clim_s[31:0];
        end else if (acc_rnd < -clim_s) begin
            corr_clamped = -clim_s[31:0];
        end else begin
            corr_clamped = acc_rnd[31:0];
        end
    end

    // Turn rate and wheel mixing.
    always_comb begin
        omega_sum = {r_turn[31], r_turn} + {r_corr[31], r_corr};
        if (omega_sum[32] != omega_sum[31]) begin
            omega_sat = omega_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            omega_sat = omega_sum[31:0];
        end
        prod_rnd  = round_q16(r_prod);
        vmax_s    = $signed({18'd0, i_max_wheel_speed});
        left_raw  = 49'(r_speed) - 49'(r_diff);
        right_raw = 49'(r_speed) + 49'(r_diff);
        if (left_raw > vmax_s) begin
            left_sat = vmax_s[31:0];
        end else if (left_raw < -vmax_s) begin
            left_sat = -vmax_s[31:0];
        end else begin
            left_sat = left_raw[31:0];
        end
        if (right_raw > vmax_s) begin
            right_sat = vmax_s[31:0];
        end else if (right_raw < -vmax_s) begin
            right_sat = -vmax_s[31:0];
        end else begin
            right_sat = right_raw[31:0];
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.op)
            OP_DIV1: begin
                mul_a = $signed({1'b0, r_mag});
                mul_b = $signed({1'b0, TICK_RECIP});
            end
            OP_DIV2: begin
                mul_a = $signed(33'(quot0));
                mul_b = TICKS_PER_SEC;
            end
            OP_PMUL: begin
                mul_a = $signed({2'd0, i_prop_gain});
                mul_b = {r_err[31], r_err};
            end
            OP_IMUL: begin
                mul_a = $signed({2'd0, i_integ_gain});
                mul_b = {r_integ[31], r_integ};
            end
            OP_MIX1: begin
                mul_a = $signed({2'd0, i_half_wheel_base});
                mul_b = {r_omega[31], r_omega};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Loop state: reset to zero and unlocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock   <= 1'b0;
            r_target <= '0;
            r_integ  <= '0;
        end else if (i_cmd.accept) begin
            case (t_req'(i_req_type))
                REQ_LOCK_ON: begin
                    r_lock   <= 1'b1;
                    r_integ  <= '0;
                    r_target <= i_gyro_angle;
                end
                REQ_LOCK_OFF: begin
                    r_lock  <= 1'b0;
                    r_integ <= '0;
                end
                REQ_ROTATE: begin
                    if (r_lock) begin
                        r_integ <= '0;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_cmd.op)
                OP_ERR:  r_target <= tgt;
                OP_DIV3: r_integ  <= integ_clamped;
                default: begin
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_gyro <= i_gyro_angle;
            r_speed <= i_planned_speed;
            r_turn <= i_planned_turn_rate;
            r_rot  <= i_rotation_active;
            r_prof <= i_profile_angle;
            r_corr <= '0;
            if (t_req'(i_req_type) == REQ_LOCK_OFF) begin
                r_left  <= '0;
                r_right <= '0;
            end
        end
        case (i_cmd.op)
            OP_ERR: begin
                r_err   <= err_z;
                r_ibase <= in_dead ? 32'sd0 : r_integ;
                r_mag   <= err_abs[31:0] + TICK_HALF;
                r_neg   <= err_z[31];
            end
            OP_DIV1:  r_prod <= mul_p[63:0];
            OP_DIV2: begin
                r_quot <= quot0;
                r_prod <= mul_p[63:0];
            end
            OP_PMUL:  r_prod <= mul_p[63:0];
            OP_IMUL: begin
                r_acc  <= r_prod;
                r_prod <= mul_p[63:0];
            end
            OP_SUM:   r_acc   <= acc_sum;
            OP_CORR:  r_corr  <= corr_clamped;
            OP_OMEGA: r_omega <= omega_sat;
            OP_MIX1:  r_prod  <= mul_p[63:0];
            OP_MIX2:  r_diff  <= prod_rnd;
            OP_MIX3: begin
                r_left  <= left_sat;
                r_right <= right_sat;
            end
            default: begin
            end
        endcase
    end

    // Output register, loaded when the finished result is handed over.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_left_speed         <= r_left;
            o_right_speed        <= r_right;
            o_heading_correction <= r_corr;
            o_lock_active        <= r_lock;
        end
    end

    assign o_sts.locked = r_lock;

endmodule

// ----- rtl/heading_pi_differential_mixer_top.sv -----
// Top level of the heading-hold PI mixer: configuration registers behind an
// APB-style port, plus the controller and datapath. Depends on hpdm_pkg.
//
// Usage. One request enters on the input channel (i_in_valid / o_in_ready) per
// control tick or event. A tick yields one result on the output channel
// (o_out_valid / i_out_ready) carrying both wheel speeds, the heading
// correction and the lock state. A lock-off-and-stop request yields one result
// with all speeds and the correction at zero. Lock-on and rotate-start requests
// update the loop state and yield no result.
// Timing. The block works on one request at a time. A tick while locked steps
// through the error, division, gain, sum, correction, turn-rate and mix states,
// and its result turns valid as the block becomes ready again; the sequence is
// set by the single shared 33 by 33 bit multiplier, used five times per locked
// tick (twice for the division of the error by the tick rate, once each for the
// two gains and once for the wheel mix) and by the rounding and clamping steps
// between them. An unlocked tick goes straight to the turn-rate and mix states,
// a lock-off request straight to the result and the other events back to idle.
// Stalls. The finished result sits in an output register; the block accepts
// and works on the next request while it waits, and only holds the following
// result back until the receiver has taken the earlier one.
// Reset (synchronous, active low) clears the configuration registers, unlocks
// the loop, zeroes the target and the integral and empties the output register.
// The user must write configuration only while the block is idle; the block itself does not enforce this.
module heading_pi_differential_mixer_top
    import hpdm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_gyro_angle,
    input  logic signed [31:0] i_planned_speed,
    input  logic signed [31:0] i_planned_turn_rate,
    input  logic               i_rotation_active,
    input  logic signed [31:0] i_profile_angle,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_left_speed,
    output logic signed [31:0] o_right_speed,
    output logic signed [31:0] o_heading_correction,
    output logic               o_lock_active,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [30:0] r_prop_gain;
    logic [30:0] r_integ_gain;
    logic [30:0] r_corr_lim_rot;
    logic [30:0] r_corr_lim_drv;
    logic [30:0] r_integ_lim_rot;
    logic [30:0] r_integ_lim_drv;
    logic [30:0] r_half_base;
    logic [30:0] r_max_wheel;

    logic        cfg_write;
    t_reg        cfg_sel;
    t_cmd        cmd;
    t_sts        sts;

    // The port never inserts wait states. Only the low 31 bits of a write are kept.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= '0;
            r_integ_gain    <= '0;
            r_corr_lim_rot  <= '0;
            r_corr_lim_drv  <= '0;
            r_integ_lim_rot <= '0;
            r_integ_lim_drv <= '0;
            r_half_base     <= '0;
            r_max_wheel     <= '0;
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_PROP_GAIN:     r_prop_gain     <= pwdata[30:0];
                REG_INTEG_GAIN:    r_integ_gain    <= pwdata[30:0];
                REG_CORR_LIM_ROT:  r_corr_lim_rot  <= pwdata[30:0];
                REG_CORR_LIM_DRV:  r_corr_lim_drv  <= pwdata[30:0];
                REG_INTEG_LIM_ROT: r_integ_lim_rot <= pwdata[30:0];
                REG_INTEG_LIM_DRV: r_integ_lim_drv <= pwdata[30:0];
                REG_HALF_BASE:     r_half_base     <= pwdata[30:0];
                REG_MAX_WHEEL:     r_max_wheel     <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the register addressed.
    always_comb begin
        case (cfg_sel)
            REG_PROP_GAIN:     prdata = {1'b0, r_prop_gain};
            REG_INTEG_GAIN:    prdata = {1'b0, r_integ_gain};
            REG_CORR_LIM_ROT:  prdata = {1'b0, r_corr_lim_rot};
            REG_CORR_LIM_DRV:  prdata = {1'b0, r_corr_lim_drv};
            REG_INTEG_LIM_ROT: prdata = {1'b0, r_integ_lim_rot};
            REG_INTEG_LIM_DRV: prdata = {1'b0, r_integ_lim_drv};
            REG_HALF_BASE:     prdata = {1'b0, r_half_base};
            REG_MAX_WHEEL:     prdata = {1'b0, r_max_wheel};
            default:           prdata = '0;
        endcase
    end

    // The controller sequences each request; the datapath holds all the arithmetic.
    hpdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    hpdm_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_req_type             (i_req_type),
        .i_gyro_angle           (i_gyro_angle),
        .i_planned_speed        (i_planned_speed),
        .i_planned_turn_rate    (i_planned_turn_rate),
        .i_rotation_active      (i_rotation_active),
        .i_profile_angle        (i_profile_angle),
        .i_prop_gain            (r_prop_gain),
        .i_integ_gain           (r_integ_gain),
        .i_corr_limit_rotating  (r_corr_lim_rot),
        .i_corr_limit_driving   (r_corr_lim_drv),
        .i_integ_limit_rotating (r_integ_lim_rot),
        .i_integ_limit_driving  (r_integ_lim_drv),
        .i_half_wheel_base      (r_half_base),
        .i_max_wheel_speed      (r_max_wheel),
        .o_left_speed           (o_left_speed),
        .o_right_speed          (o_right_speed),
        .o_heading_correction   (o_heading_correction),
        .o_lock_active          (o_lock_active)
    );

endmodule
